### rtl/sorted_array_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// sorted array priority queue assertion macros
// shared property forms for the queue core checks
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define SAPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// types, codes and defaults shared by the sorted array priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 4;
    localparam int M_TDATA_W     = 40;

    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic        [STATUS_W-1:0] status_t;
    typedef logic        [COUNT_W-1:0]  count_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

### rtl/sapq_ctrl.sv
// ----------------------------------------------------------------------------
// sapq_ctrl
// request sequencer: takes an item, runs one update, holds the result valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapq_ctrl
    import sapq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

### rtl/sapq_datapath.sv
// ----------------------------------------------------------------------------
// sapq_datapath
// chain of compare-and-shift cells holding the sorted entries, plus result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapq_datapath
    import sapq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    cmd,
    input  logic    req_type,
    input  value_t  value,
    output status_t status,
    output count_t  count,
    output logic    head_valid,
    output value_t  head_value
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             req_type_reg;
    value_t           value_reg;
    value_t           entries_reg [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;

    status_t          status_reg;
    count_t           count_out_reg;
    logic             head_valid_reg;
    value_t           head_value_reg;

    logic [DEPTH-1:0] live, ge, eq, ins_mark, del_mark;
    value_t           ins_val [DEPTH];
    value_t           del_val [DEPTH];
    value_t           nxt_val [DEPTH];

    logic    full, empty, found, wr_ins, wr_del;
    status_t status_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign found = |eq;

    assign wr_ins = (req_type_reg == REQ_INSERT) && !full;
    assign wr_del = (req_type_reg == REQ_DELETE) && found;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            assign live[k]     = (CNT_W'(k) < count_reg);
            assign ge[k]       = live[k] && (value_reg >= entries_reg[k]);
            assign eq[k]       = live[k] && (value_reg == entries_reg[k]);
            assign ins_mark[k] = ge[k] || !live[k];

            if (k == 0) begin : g_first
                assign del_mark[k] = eq[k];
                assign ins_val[k]  = ins_mark[k] ? value_reg : entries_reg[k];
            end else begin : g_rest
                assign del_mark[k] = del_mark[k-1] | eq[k];
                assign ins_val[k]  = !ins_mark[k]  ? entries_reg[k]
                                   : ins_mark[k-1] ? entries_reg[k-1] : value_reg;
            end

            if (k == DEPTH - 1) begin : g_last
                assign del_val[k] = entries_reg[k];
            end else begin : g_mid
                assign del_val[k] = del_mark[k] ? entries_reg[k+1] : entries_reg[k];
            end

            assign nxt_val[k] = wr_ins ? ins_val[k] : wr_del ? del_val[k] : entries_reg[k];

            always_ff @(posedge aclk) begin
                if (cmd.exec) begin
                    entries_reg[k] <= nxt_val[k];
                end
            end
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (req_type_reg == REQ_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else if (!found) begin
                status_next = ST_NOT_FOUND;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= req_type;
            value_reg    <= value;
        end
        if (cmd.exec) begin
            status_reg     <= status_next;
            count_out_reg  <= COUNT_W'(count_next);
            head_valid_reg <= (count_next != '0);
            head_value_reg <= (count_next != '0) ? nxt_val[0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    assign status     = status_reg;
    assign count      = count_out_reg;
    assign head_valid = head_valid_reg;
    assign head_value = head_value_reg;

endmodule

### rtl/sorted_array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// descending sorted queue of signed values with insert and delete requests
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | s_tuser req_type, s_tdata value
//  m_      | out | m_tvalid / m_tready | m_tdata status, count, head
//
// an item first has its request registered, then gets the
// compare-and-shift pass over all cells and the result register load
// a new item is taken while the previous result still waits on m_tready
// the update stalls in its compare-and-shift step while a result is held unaccepted
// aresetn (a synchronous reset) empties the queue; entry contents are left as they are
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_array_priority_queue_core_assert.svh"

module sorted_array_priority_queue_core
    import sapq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // [0] req_type
    input  logic [VALUE_W-1:0]   s_tdata,   // [31:0] value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [1:0] status, [5:2] count,
                                            // [6] head_valid, [38:7] head_value
);

    cmd_t    cmd;
    status_t status;
    count_t  count;
    logic    head_valid;
    value_t  head_value;

    sapq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sapq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req_type   (s_tuser),
        .value      (value_t'(s_tdata)),
        .status     (status),
        .count      (count),
        .head_valid (head_valid),
        .head_value (head_value)
    );

    assign m_tdata = {1'b0, head_value, head_valid, count, status};

    `SAPQ_ASSERT_NOW(a_load_only_on_accept, cmd.load, s_tvalid && s_tready, "load without accept")
    `SAPQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `SAPQ_ASSERT_NEXT(a_exec_gives_result, cmd.exec, m_tvalid, "update without a result")
    `SAPQ_ASSERT_NOW(a_empty_head_zero, m_tvalid && !m_tdata[6], m_tdata[38:7] == '0, "head not zero when empty")

endmodule
